[rtl/cmdl_pkg.sv]
// ----------------------------------------------------------------------------
// cmdl_pkg: shared constants and types of the command line editor
// Character codes, word kinds and the line step record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmdl_pkg;

   // default line buffer length
   localparam int LINE_LENGTH_DEF = 32;

   // slots that the command match looks at (longest word plus terminator)
   localparam int MATCH_SLOTS = 5;

   // character codes
   localparam logic [7:0] CHAR_NUL    = 8'd0;
   localparam logic [7:0] CHAR_BS     = 8'd8;
   localparam logic [7:0] CHAR_LF     = 8'd10;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_DEL    = 8'd127;
   localparam logic [7:0] CHAR_IGNORE = 8'd255;

   // command codes
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_HELP = 2'd1;
   localparam logic [1:0] CMD_AUS  = 2'd2;
   localparam logic [1:0] CMD_AN   = 2'd3;

   // kind of echo burst
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_ENTER  = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   // one character handed to the line buffer
   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
   } step_type;

endpackage

`default_nettype wire

[rtl/cmdl_line.sv]
// ----------------------------------------------------------------------------
// cmdl_line: line buffer, write positions and command match
// Applies one character per step and reports which command the line holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmdl_line #(
   parameter int LINE_LENGTH = cmdl_pkg::LINE_LENGTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmdl_pkg::step_type step,
   output logic [1:0]              command_code
);

   localparam int PW = $clog2(LINE_LENGTH);
   localparam int NS = cmdl_pkg::MATCH_SLOTS;
   localparam logic [PW:0] LAST_POS = (PW + 1)'(LINE_LENGTH - 1);

   // only the head of the line can ever match a command word
   logic [7:0]    slot_ff [NS];
   logic [7:0]    slot_in [NS];
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] prev_ff, prev_in;
   logic [PW:0]   wp_inc;
   logic [PW-1:0] wp_next;

   // saturating step of the write position
   always_comb begin
      wp_inc  = {1'b0, wp_ff} + (PW + 1)'(1);
      wp_next = (wp_inc >= LAST_POS) ? LAST_POS[PW-1:0] : wp_inc[PW-1:0];
   end

   // next state of positions and head slots
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      wp_in   = wp_ff;
      prev_in = prev_ff;
      if (step.valid) begin
         case (step.ch)
            cmdl_pkg::CHAR_CR: begin
               slot_in[0] = cmdl_pkg::CHAR_NUL;
               wp_in      = '0;
               prev_in    = '0;
            end
            cmdl_pkg::CHAR_DEL: begin
               wp_in = prev_ff;
               for (int i = 0; i < NS; i++) begin
                  if (prev_ff == PW'(i)) begin
                     slot_in[i] = cmdl_pkg::CHAR_NUL;
                  end
               end
            end
            default: begin
               prev_in = wp_ff;
               wp_in   = wp_next;
               // terminator after the new character wins when saturated
               for (int i = 0; i < NS; i++) begin
                  if (wp_next == PW'(i)) begin
                     slot_in[i] = cmdl_pkg::CHAR_NUL;
                  end else if (wp_ff == PW'(i)) begin
                     slot_in[i] = step.ch;
                  end
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            slot_ff[i] <= cmdl_pkg::CHAR_NUL;
         end
         wp_ff   <= '0;
         prev_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
         wp_ff   <= wp_in;
         prev_ff <= prev_in;
      end
   end

   // exact match against the command words
   always_comb begin
      if (slot_ff[0] == 8'h68 && slot_ff[1] == 8'h65 && slot_ff[2] == 8'h6C &&
          slot_ff[3] == 8'h70 && slot_ff[4] == cmdl_pkg::CHAR_NUL) begin
         command_code = cmdl_pkg::CMD_HELP;
      end else if (slot_ff[0] == 8'h61 && slot_ff[1] == 8'h6E &&
                   slot_ff[2] == cmdl_pkg::CHAR_NUL) begin
         command_code = cmdl_pkg::CMD_AN;
      end else if (slot_ff[0] == 8'h61 && slot_ff[1] == 8'h75 && slot_ff[2] == 8'h73 &&
                   slot_ff[3] == cmdl_pkg::CHAR_NUL) begin
         command_code = cmdl_pkg::CMD_AUS;
      end else begin
         command_code = cmdl_pkg::CMD_NONE;
      end
   end

endmodule

`default_nettype wire

[rtl/serial_command_line_editor_unit.sv]
// ----------------------------------------------------------------------------
// serial_command_line_editor_unit: terminal line editor with command match
// Echoes received characters, handles enter and delete, reports commands.
// ----------------------------------------------------------------------------
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  req     | req_valid req_ready req_rx_char                    | in
//  rsp     | rsp_valid rsp_ready rsp_echo_char rsp_command_code | out
//          | rsp_command_valid rsp_last                         |
//
//  An ordinary character gives one word, enter two, delete three; the echo
//  sequencer emits one word per cycle while rsp_ready is high.
//  A byte of 255 is dropped at the input.
//  One input register holds the next character while a burst is stalled.
//  Reset clears the line buffer head, positions and all valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_editor_unit #(
   parameter int LINE_LENGTH = cmdl_pkg::LINE_LENGTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_char,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_echo_char,
   output logic [1:0]      rsp_command_code,
   output logic            rsp_command_valid,
   output logic            rsp_last
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;

   // echo burst
   logic       busy_ff, busy_in;
   logic [1:0] kind_ff;
   logic [7:0] char_ff;
   logic [1:0] code_ff;
   logic [1:0] idx_ff, idx_in;

   logic             advance, done, load, req_accept;
   logic [1:0]       match_code;
   logic [1:0]       load_kind;
   cmdl_pkg::step_type step;

   // handshake control
   assign advance    = busy_ff && rsp_ready;
   assign done       = advance && rsp_last;
   assign load       = in_valid_ff && (!busy_ff || done);
   assign req_ready  = !in_valid_ff || load;
   assign req_accept = req_valid && req_ready;
   assign in_valid_in = (in_valid_ff && !load) ||
                        (req_accept && req_rx_char != cmdl_pkg::CHAR_IGNORE);
   assign busy_in    = load || (busy_ff && !done);

   // burst kind of the character being loaded
   always_comb begin
      case (in_char_ff)
         cmdl_pkg::CHAR_CR:  load_kind = cmdl_pkg::KIND_ENTER;
         cmdl_pkg::CHAR_DEL: load_kind = cmdl_pkg::KIND_DELETE;
         default:            load_kind = cmdl_pkg::KIND_CHAR;
      endcase
   end

   // word index within the burst
   always_comb begin
      if (load) begin
         idx_in = 2'd0;
      end else if (advance) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   // line buffer
   assign step.valid = load;
   assign step.ch    = in_char_ff;

   cmdl_line #(
      .LINE_LENGTH(LINE_LENGTH)
   ) u_line (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .command_code(match_code)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         busy_ff     <= 1'b0;
         idx_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         busy_ff     <= busy_in;
         idx_ff      <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_rx_char;
      end
      if (load) begin
         kind_ff <= load_kind;
         char_ff <= in_char_ff;
         code_ff <= match_code;
      end
   end

   // word selection
   always_comb begin
      rsp_valid         = busy_ff;
      rsp_command_code  = cmdl_pkg::CMD_NONE;
      rsp_command_valid = 1'b0;
      case (kind_ff)
         cmdl_pkg::KIND_ENTER: begin
            rsp_last = (idx_ff == 2'd1);
            if (rsp_last) begin
               rsp_echo_char     = cmdl_pkg::CHAR_CR;
               rsp_command_code  = code_ff;
               rsp_command_valid = 1'b1;
            end else begin
               rsp_echo_char = cmdl_pkg::CHAR_LF;
            end
         end
         cmdl_pkg::KIND_DELETE: begin
            rsp_last      = (idx_ff == 2'd2);
            rsp_echo_char = (idx_ff == 2'd1) ? cmdl_pkg::CHAR_SPACE : cmdl_pkg::CHAR_BS;
         end
         default: begin
            rsp_last      = 1'b1;
            rsp_echo_char = char_ff;
         end
      endcase
   end

   // checks
   a_enter_starts_lf : assert property (@(posedge clock) disable iff (reset)
      load && in_char_ff == cmdl_pkg::CHAR_CR |=>
         rsp_valid && rsp_echo_char == cmdl_pkg::CHAR_LF)
      else $error("enter burst does not start with line feed");

   a_cmd_on_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_valid |-> rsp_last && kind_ff == cmdl_pkg::KIND_ENTER)
      else $error("command reported off the final enter word");

   a_drain_idle : assert property (@(posedge clock) disable iff (reset)
      done && !in_valid_ff |=> !rsp_valid)
      else $error("words after the end of a burst");

   a_delete_three : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind_ff == cmdl_pkg::KIND_DELETE && rsp_last |-> idx_ff == 2'd2)
      else $error("delete burst ended early");

endmodule

`default_nettype wire

[tb/serial_command_line_editor_unit_tb.sv]
// ----------------------------------------------------------------------------
// serial_command_line_editor_unit_tb: self-checking bench of the line editor
// Sends received characters in random bursts and keeps its own copy of the
// line buffer to predict every echo word and command code. Each word that
// leaves the block is compared field by field against the oldest prediction
// while the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_command_line_editor_unit_tb;

   localparam int LINE_LEN    = cmdl_pkg::LINE_LENGTH_DEF;
   localparam int CYCLE_LIMIT = 200000;

   // one echo word as it leaves the block
   typedef struct packed {
      logic [7:0] echo_char;
      logic [1:0] command_code;
      logic       command_valid;
      logic       last;
   } echo_word_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_char = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_echo_char;
   logic [1:0] rsp_command_code;
   logic       rsp_command_valid;
   logic       rsp_last;

   // pending characters and predicted echo words
   logic [7:0]    rx_char_q[$];
   echo_word_type pending_echo_q[$];

   // predicted editor state
   logic [7:0] line_buf [LINE_LEN];
   int         write_pos = 0;
   int         prev_pos  = 0;

   int             error_count = 0;
   int             live_items  = 0;
   int             burst_left  = 1;
   int             gap_left    = 0;
   int             stall_phase = 0;
   int             cycle_count = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   logic [7:0]     stall_pattern = 8'hFF;

   serial_command_line_editor_unit #(
      .LINE_LENGTH(LINE_LEN)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_char      (req_rx_char),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_echo_char    (rsp_echo_char),
      .rsp_command_code (rsp_command_code),
      .rsp_command_valid(rsp_command_valid),
      .rsp_last         (rsp_last)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // line compare up to the first zero byte, end of buffer also ends it
   function automatic logic line_is(string w);
      logic [7:0] have;
      for (int i = 0; i <= w.len(); i++) begin
         have = (i < LINE_LEN) ? line_buf[i] : cmdl_pkg::CHAR_NUL;
         if (i == w.len())
            return have == cmdl_pkg::CHAR_NUL;
         if (have != w[i])
            return 1'b0;
      end
      return 1'b0;
   endfunction

   // apply one character to the predicted line and queue its echo words
   function automatic void edit_line(logic [7:0] ch);
      logic [1:0] code;
      if (ch == cmdl_pkg::CHAR_IGNORE)
         return;
      if (ch == cmdl_pkg::CHAR_CR) begin
         code = cmdl_pkg::CMD_NONE;
         if (line_is("help"))
            code = cmdl_pkg::CMD_HELP;
         else if (line_is("an"))
            code = cmdl_pkg::CMD_AN;
         else if (line_is("aus"))
            code = cmdl_pkg::CMD_AUS;
         pending_echo_q.push_back('{cmdl_pkg::CHAR_LF, cmdl_pkg::CMD_NONE, 1'b0, 1'b0});
         pending_echo_q.push_back('{cmdl_pkg::CHAR_CR, code, 1'b1, 1'b1});
         line_buf[0] = cmdl_pkg::CHAR_NUL;
         write_pos   = 0;
         prev_pos    = 0;
      end else if (ch == cmdl_pkg::CHAR_DEL) begin
         pending_echo_q.push_back('{cmdl_pkg::CHAR_BS, cmdl_pkg::CMD_NONE, 1'b0, 1'b0});
         pending_echo_q.push_back('{cmdl_pkg::CHAR_SPACE, cmdl_pkg::CMD_NONE, 1'b0, 1'b0});
         pending_echo_q.push_back('{cmdl_pkg::CHAR_BS, cmdl_pkg::CMD_NONE, 1'b0, 1'b1});
         // single level undo
         write_pos = prev_pos;
         line_buf[write_pos] = cmdl_pkg::CHAR_NUL;
      end else begin
         pending_echo_q.push_back('{ch, cmdl_pkg::CMD_NONE, 1'b0, 1'b1});
         line_buf[write_pos] = ch;
         prev_pos = write_pos;
         if (write_pos < LINE_LEN - 1)
            write_pos++;
         line_buf[write_pos] = cmdl_pkg::CHAR_NUL;
      end
   endfunction

   task automatic push_char(logic [7:0] ch);
      rx_char_q.push_back(ch);
      if (ch != cmdl_pkg::CHAR_IGNORE)
         live_items++;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i]);
   endtask

   // printable-ish byte that is neither enter, delete nor ignored
   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      b = 8'($urandom_range(1, 254));
      if (b == cmdl_pkg::CHAR_CR || b == cmdl_pkg::CHAR_DEL)
         b = "x";
      return b;
   endfunction

   // one well-formed line with random typos fixed by delete, then enter
   task automatic push_line();
      string variants[8] = '{"hel", "helpp", "au", "ausa", "a", "ann", "Help", "xan"};
      string w;
      int    n;
      w = "";
      case ($urandom_range(0, 9))
         0, 1: w = "help";
         2, 3: w = "aus";
         4, 5: w = "an";
         6: w = variants[$urandom_range(0, 7)];
         8: w = "";
         9: begin
            // overlong line, only now and then
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(LINE_LEN + 1, LINE_LEN + 4) : 3;
            for (int i = 0; i < n; i++)
               w = {w, string'(plain_char())};
         end
         default: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               w = {w, string'(8'($urandom_range("a", "z")))};
         end
      endcase
      for (int i = 0; i < w.len(); i++) begin
         if ($urandom_range(0, 5) == 0) begin
            push_char(plain_char());
            push_char(cmdl_pkg::CHAR_DEL);
            if ($urandom_range(0, 2) == 0)
               push_char(cmdl_pkg::CHAR_DEL);
         end
         if ($urandom_range(0, 11) == 0)
            push_char(cmdl_pkg::CHAR_IGNORE);
         push_char(w[i]);
      end
      push_char(cmdl_pkg::CHAR_CR);
   endtask

   // stimulus, reset and end of run
   initial begin : main_seq
      int target;
      for (int i = 0; i < LINE_LEN; i++)
         line_buf[i] = cmdl_pkg::CHAR_NUL;

      // directed: ignored byte, delete on empty line, each command
      push_char(cmdl_pkg::CHAR_IGNORE);
      push_char(cmdl_pkg::CHAR_DEL);
      push_text("help");
      push_char(cmdl_pkg::CHAR_CR);
      push_text("aus");
      push_char(cmdl_pkg::CHAR_CR);
      push_text("an");
      push_char(cmdl_pkg::CHAR_CR);
      // zero byte ends the line early
      push_text("an");
      push_char(cmdl_pkg::CHAR_NUL);
      push_text("x");
      push_char(cmdl_pkg::CHAR_CR);
      // typo removed by delete, second delete does nothing more
      push_text("helpx");
      push_char(cmdl_pkg::CHAR_DEL);
      push_char(cmdl_pkg::CHAR_DEL);
      push_char(cmdl_pkg::CHAR_CR);
      // empty line
      push_char(cmdl_pkg::CHAR_CR);

      // random: mostly lines, some raw noise over the whole byte range
      target = 100;
      while (live_items < target) begin
         if ($urandom_range(0, 9) < 7)
            push_line();
         else
            repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (rx_char_q.size() != 0 || req_valid)
         @(posedge clock);
      while (pending_echo_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // sender: bursts of words with random gaps
   always @(posedge clock) begin : req_driver
      logic take;
      take = req_valid && req_ready;
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_char <= 8'd0;
      end else begin
         if (take)
            edit_line(req_rx_char);
         if (!req_valid || take) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_char_q.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_char <= rx_char_q.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall mode is picked anew at random from none, random and pattern
   always @(posedge clock) begin : rsp_stall
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_phase++;
         if (stall_phase % 64 == 0) begin
            stall_mode    = stall_mode_type'($urandom_range(0, 2));
            stall_pattern = 8'($urandom_range(1, 255));
         end
         case (stall_mode)
            STALL_NONE:   rsp_ready <= 1'b1;
            STALL_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
            default:      rsp_ready <= stall_pattern[stall_phase % 8];
         endcase
      end
   end

   // checker: each accepted word against the oldest prediction
   always @(posedge clock) begin : echo_monitor
      echo_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_echo_q.size() == 0) begin
            $error("unexpected word: echo_char %0d", rsp_echo_char);
            error_count++;
         end else begin
            want = pending_echo_q.pop_front();
            if (rsp_echo_char !== want.echo_char) begin
               $error("echo_char: expected %0d, got %0d", want.echo_char, rsp_echo_char);
               error_count++;
            end
            if (rsp_command_code !== want.command_code) begin
               $error("command_code: expected %0d, got %0d",
                      want.command_code, rsp_command_code);
               error_count++;
            end
            if (rsp_command_valid !== want.command_valid) begin
               $error("command_valid: expected %0d, got %0d",
                      want.command_valid, rsp_command_valid);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
